[hdl/kdb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdb_pkg
// Shared types and constants for the debounced key scanner with key FIFO.
// ----------------------------------------------------------------------------
package kdb_pkg;

    localparam int unsigned MASK_W       = 3;
    localparam int unsigned CODE_W       = 4;
    localparam int unsigned FT_W         = 7;
    localparam int unsigned LT_W         = 12;
    localparam int unsigned CNT_W        = 8;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 12;
    localparam int unsigned OPQ_DEPTH    = 4;
    localparam int unsigned OUT_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME   = 1'd1;

    localparam logic [FT_W-1:0]  FILTER_TIME_RST = 7'd5;
    localparam logic [LT_W-1:0]  LONG_TIME_RST   = 12'd100;
    localparam logic [CNT_W-1:0] FILTER_CNT_RST  = 8'd2;

    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;

    typedef struct packed {
        logic              is_pop;
        logic [CODE_W-1:0] code;
    } op_t;

    function automatic logic [CODE_W-1:0] key_code_of(input int unsigned button,
                                                     input logic [1:0] ev_kind);
        logic [7:0] v;
        v = 8'(3 * button) + {6'd0, ev_kind};
        return v[CODE_W-1:0];
    endfunction

endpackage

[hdl/kdb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdb_front
// Accepts words, runs the per-button debounce filters and emits ordered ops.
// ----------------------------------------------------------------------------
module kdb_front #(
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             kind,
    input  logic [kdb_pkg::MASK_W-1:0]       pressed_mask,
    output logic                             full,
    input  logic                             cfg_valid,
    input  logic [kdb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kdb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             cfg_ready,
    output logic                             op_valid,
    output kdb_pkg::op_t                     op,
    input  logic                             op_full
);
    import kdb_pkg::*;

    localparam int unsigned SLOTS = 2 * NUM_BUTTONS;
    localparam int unsigned SEL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned EXT_W = (NUM_BUTTONS > MASK_W) ? NUM_BUTTONS : MASK_W;

    logic [FT_W-1:0]  filter_time_reg;
    logic [LT_W-1:0]  long_time_reg;

    logic [CNT_W-1:0] cnt_reg  [NUM_BUTTONS];
    logic [CNT_W-1:0] cnt_next [NUM_BUTTONS];
    logic             down_reg  [NUM_BUTTONS];
    logic             down_next [NUM_BUTTONS];
    logic [LT_W-1:0]  held_reg  [NUM_BUTTONS];
    logic [LT_W-1:0]  held_next [NUM_BUTTONS];

    logic [SLOTS-1:0] pend_vld_reg;
    logic [SLOTS-1:0] pend_vld_next;
    op_t              pend_op_reg  [SLOTS];
    op_t              pend_op_next [SLOTS];

    logic [SLOTS-1:0] tick_vld;
    op_t              tick_op [SLOTS];

    logic [EXT_W-1:0]       mask_ext;
    logic [NUM_BUTTONS-1:0] pressed_vec;
    logic [CNT_W-1:0]       ft8;
    logic [CNT_W-1:0]       ft2;
    logic [SEL_W-1:0]       sel;
    logic [SLOTS-1:0]       grant_vec;
    logic [SLOTS-1:0]       remain;
    logic                   accept;

    assign mask_ext    = EXT_W'(pressed_mask);
    assign pressed_vec = mask_ext[NUM_BUTTONS-1:0];
    assign ft8         = {1'b0, filter_time_reg};
    assign ft2         = {filter_time_reg, 1'b0};
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        logic [LT_W-1:0] held_inc;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            cnt_next[b]      = cnt_reg[b];
            down_next[b]     = down_reg[b];
            held_next[b]     = held_reg[b];
            tick_vld[2*b]    = 1'b0;
            tick_vld[2*b+1]  = 1'b0;
            tick_op[2*b]     = '{is_pop: 1'b0, code: key_code_of(b, EV_PRESS)};
            tick_op[2*b+1]   = '{is_pop: 1'b0, code: key_code_of(b, EV_LONG)};
            held_inc         = held_reg[b] + 1'b1;
            if (pressed_vec[b])
            begin
                if (cnt_reg[b] < ft8)
                begin
                    cnt_next[b] = ft8;
                end
                else if (cnt_reg[b] < ft2)
                begin
                    cnt_next[b] = cnt_reg[b] + 1'b1;
                end
                else
                begin
                    if (!down_reg[b])
                    begin
                        down_next[b] = 1'b1;
                        tick_vld[2*b] = 1'b1;
                    end
                    if ((long_time_reg != '0) && (held_reg[b] < long_time_reg))
                    begin
                        held_next[b] = held_inc;
                        tick_vld[2*b+1] = (held_inc == long_time_reg);
                    end
                end
            end
            else
            begin
                held_next[b] = '0;
                if (cnt_reg[b] > ft8)
                begin
                    cnt_next[b] = ft8;
                end
                else if (cnt_reg[b] != '0)
                begin
                    cnt_next[b] = cnt_reg[b] - 1'b1;
                end
                else if (down_reg[b])
                begin
                    down_next[b] = 1'b0;
                    tick_vld[2*b] = 1'b1;
                    tick_op[2*b].code = key_code_of(b, EV_RELEASE);
                end
            end
        end
    end

    always_comb
    begin
        sel = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (pend_vld_reg[s])
            begin
                sel = SEL_W'(s);
            end
        end
    end

    assign op_valid  = |pend_vld_reg;
    assign op        = pend_op_reg[sel];
    assign grant_vec = (op_valid && !op_full) ? (SLOTS'(1) << sel) : '0;
    assign remain    = pend_vld_reg & ~grant_vec;
    assign full      = |remain;
    assign accept    = push && !full;

    always_comb
    begin
        pend_vld_next = remain;
        for (int s = 0; s < SLOTS; s++)
        begin
            pend_op_next[s] = pend_op_reg[s];
        end
        if (accept)
        begin
            if (kind)
            begin
                pend_vld_next   = SLOTS'(1);
                pend_op_next[0] = '{is_pop: 1'b1, code: CODE_NONE};
            end
            else
            begin
                pend_vld_next = tick_vld;
                for (int s = 0; s < SLOTS; s++)
                begin
                    pend_op_next[s] = tick_op[s];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg <= FILTER_TIME_RST;
            long_time_reg   <= LONG_TIME_RST;
            pend_vld_reg    <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                cnt_reg[b]  <= FILTER_CNT_RST;
                down_reg[b] <= 1'b0;
                held_reg[b] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_FILTER_TIME))
            begin
                filter_time_reg <= cfg_data[FT_W-1:0];
            end
            if (cfg_valid && (cfg_index == REG_LONG_TIME))
            begin
                long_time_reg <= cfg_data[LT_W-1:0];
            end
            pend_vld_reg <= pend_vld_next;
            if (accept && !kind)
            begin
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    cnt_reg[b]  <= cnt_next[b];
                    down_reg[b] <= down_next[b];
                    held_reg[b] <= held_next[b];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            pend_op_reg[s] <= pend_op_next[s];
        end
    end

`ifndef ASSERT_OFF
    a_pop_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind) |=> (pend_vld_reg == SLOTS'(1) && pend_op_reg[0].is_pop))
        else $error("A pop word did not load exactly one pop op.");
`endif

endmodule

[hdl/kdb_opq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdb_opq
// Short op queue that decouples the scanner front from the key FIFO back end.
// ----------------------------------------------------------------------------
module kdb_opq (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_en,
    input  kdb_pkg::op_t push_op,
    output logic         full,
    input  logic         pop_en,
    output kdb_pkg::op_t head_op,
    output logic         empty
);
    import kdb_pkg::*;

    localparam int unsigned PTR_W = $clog2(OPQ_DEPTH);
    localparam int unsigned CNT_QW = $clog2(OPQ_DEPTH + 1);

    op_t               slot_reg [OPQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == CNT_QW'(OPQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];
    assign do_push = push_en && !full;
    assign do_pop  = pop_en && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hdl/kdb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdb_back
// Executes ops against the key ring FIFO and queues pop results for output.
// ----------------------------------------------------------------------------
module kdb_back #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_empty,
    input  kdb_pkg::op_t                  op_head,
    output logic                          op_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [kdb_pkg::CODE_W-1:0]    key_code
);
    import kdb_pkg::*;

    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned OPTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);

    logic [CODE_W-1:0] key_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;
    logic              key_full;
    logic              key_empty;

    logic              rd_valid_reg;
    logic              rd_zero_reg;
    logic [CODE_W-1:0] rd_data_reg;
    logic [CODE_W-1:0] rd_code;

    logic [CODE_W-1:0] out_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] out_wr_reg;
    logic [OPTR_W-1:0] out_rd_reg;
    logic [OCNT_W-1:0] out_cnt_reg;
    logic              out_room;
    logic              out_take;

    logic              exec_push;
    logic              exec_pop;
    logic              key_write;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head_inc  = ptr_inc(head_reg);
    assign tail_inc  = ptr_inc(tail_reg);
    assign key_full  = (tail_inc == head_reg);
    assign key_empty = (head_reg == tail_reg);

    assign out_room  = (out_cnt_reg + OCNT_W'(rd_valid_reg)) < OCNT_W'(OUT_DEPTH);
    assign op_pop    = !op_empty && (!op_head.is_pop || out_room);
    assign exec_push = op_pop && !op_head.is_pop;
    assign exec_pop  = op_pop && op_head.is_pop;
    assign key_write = exec_push && !key_full;

    assign rd_code   = rd_zero_reg ? CODE_NONE : rd_data_reg;
    assign empty     = (out_cnt_reg == '0);
    assign key_code  = out_reg[out_rd_reg];
    assign out_take  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_zero_reg  <= 1'b0;
            out_wr_reg   <= '0;
            out_rd_reg   <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= exec_pop;
            if (exec_pop)
            begin
                rd_zero_reg <= key_empty;
                if (!key_empty)
                begin
                    head_reg <= head_inc;
                end
            end
            if (key_write)
            begin
                tail_reg <= tail_inc;
            end
            if (rd_valid_reg)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (out_take)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            if (rd_valid_reg && !out_take)
            begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end
            else if (out_take && !rd_valid_reg)
            begin
                out_cnt_reg <= out_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_write)
        begin
            key_mem[tail_reg] <= op_head.code;
        end
        rd_data_reg <= key_mem[head_reg];
        if (rd_valid_reg)
        begin
            out_reg[out_wr_reg] <= rd_code;
        end
    end

`ifndef ASSERT_OFF
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (out_cnt_reg < OCNT_W'(OUT_DEPTH)))
        else $error("A pop result arrived with the result queue full.");

    a_write_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        key_write |=> (head_reg != tail_reg))
        else $error("The key FIFO reads as empty right after a write.");

    a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_pop && key_empty) |=> (rd_valid_reg && rd_zero_reg))
        else $error("A pop from the empty key FIFO did not return code zero.");
`endif

endmodule

[hdl/button_debounce_long_press_key_fifo_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_key_fifo_top
// Debounced button scanner with long-press detection and a key-code FIFO.
// ----------------------------------------------------------------------------
// Input words enter through push/full: kind 0 is a sample tick carrying the
// pressed levels, kind 1 asks for the oldest key code. Each pop word yields
// exactly one result word on empty/pop, with code zero when no key is queued;
// ticks yield none.
// The cfg channel writes filter_time (index 0) and long_time (index 1); it is
// always ready and must be used only while the block is idle.
// A tick holds the scanner until every key code it raises, at most two per
// button, has gone to the op queue; pops and ticks that raise no code can
// stream back to back while the op queue has room.
// A pop word reaches the result ports through the front op register, the op
// queue, the registered key FIFO read and the result queue, in that order,
// and can be taken once empty is low.
// When pop stays low the result queue fills, the back end stops taking pop
// ops, the op queue fills and full rises; no pop word or result is lost.
// Reset sets every filter counter to FILTER_CNT_RST, empties all queues and
// restores the register defaults.
// ----------------------------------------------------------------------------
module button_debounce_long_press_key_fifo_top #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            kind,
    input  logic [kdb_pkg::MASK_W-1:0]      pressed_mask,
    output logic                            empty,
    input  logic                            pop,
    output logic [kdb_pkg::CODE_W-1:0]      key_code,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kdb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kdb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kdb_pkg::*;

    logic op_valid;
    op_t  front_op;
    logic opq_full;
    logic opq_empty;
    op_t  opq_head;
    logic opq_pop;

    kdb_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .kind         (kind),
        .pressed_mask (pressed_mask),
        .full         (full),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_ready    (cfg_ready),
        .op_valid     (op_valid),
        .op           (front_op),
        .op_full      (opq_full)
    );

    kdb_opq u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (op_valid),
        .push_op (front_op),
        .full    (opq_full),
        .pop_en  (opq_pop),
        .head_op (opq_head),
        .empty   (opq_empty)
    );

    kdb_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (opq_empty),
        .op_head  (opq_head),
        .op_pop   (opq_pop),
        .empty    (empty),
        .pop      (pop),
        .key_code (key_code)
    );

endmodule
